>>> rtl/stal_pkg.sv
// Shared types, commands and register indexes for the symbol table address lookup.
package stal_pkg;

  localparam int unsigned CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT   = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STRTAB_SIZE   = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_TYPE   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_FUNCTION_TYPE = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LINE_TYPE     = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INCLUDED_TYPE = 8'd5;

  typedef struct packed {
    logic        action;
    logic [11:0] entry_index;
    logic [7:0]  entry_kind;
    logic [15:0] entry_description;
    logic [31:0] entry_value;
    logic [31:0] entry_string;
    logic [31:0] query_address;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic        file_name_valid;
    logic [31:0] file_name_offset;
    logic        function_name_valid;
    logic [31:0] function_name_offset;
    logic [31:0] function_start;
    logic [15:0] line_number;
  } out_word_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INIT_FILE,
    CMD_MID,
    CMD_LO_UP,
    CMD_RD_PICK,
    CMD_DEC,
    CMD_CMP,
    CMD_FAIL,
    CMD_INIT_FUNC,
    CMD_RD_LEFT,
    CMD_FUNC_APPLY,
    CMD_LINE_APPLY,
    CMD_FILE_NONE,
    CMD_FILE_APPLY
  } cmd_t;

  typedef struct packed {
    logic loop_done;
    logic pick_below;
    logic kind_hit;
    logic left_zero;
    logic scan_below;
    logic scan_stop;
  } dp_status_t;

endpackage

>>> rtl/symbol_table_address_lookup_top.sv
// Top level of the symbol table address lookup.
// Use: drive in_word and raise start; a word is taken at an edge where start is high
// and busy is low. A load word (action 0) writes one table slot in that cycle and gives
// no result; busy stays low so loads may follow every cycle.
// A lookup word (action 1) runs three typed binary searches over the table, then a
// backward scan for the file name entry; when no source file is found it stops after
// the first search. The table is one memory with a single registered read port.
// Busy stays high while the searches and the scan run; the table contents set how
// long that lasts.
// The result appears on out_result with out_valid high for exactly one cycle, the
// first cycle in which busy is low; the receiver cannot stall it, so it must take it
// then. The next word may be taken at the edge that ends that cycle.
// Configuration writes use cfg_valid/cfg_ready (ready is always high) with cfg_index
// and cfg_data; write only while busy is low.
// Reset (rst_n low, synchronous) returns to idle and restores register defaults;
// table contents are not cleared and slots must be loaded before they are searched.
module symbol_table_address_lookup_top #(
  parameter int TABLE_DEPTH  = 4096,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  stal_pkg::in_word_t                in_word,
  output logic                              out_valid,
  output stal_pkg::out_word_t               out_result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [stal_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data
);
  import stal_pkg::*;

  cmd_t       cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  stal_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .action    (in_word.action),
    .status    (status),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  stal_datapath #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_word   (in_word),
    .cfg_valid (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .result    (out_result)
  );

endmodule

>>> rtl/stal_datapath.sv
// Datapath: symbol table memory, search registers, configuration and result word.
module stal_datapath #(
  parameter int TABLE_DEPTH  = 4096,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  stal_pkg::cmd_t                    cmd,
  input  stal_pkg::in_word_t                in_word,
  input  logic                              cfg_valid,
  input  logic [stal_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [31:0]                       cfg_data,
  output stal_pkg::dp_status_t              status,
  output stal_pkg::out_word_t               result
);
  import stal_pkg::*;

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SW = IW + 2;
  localparam int AW = ADDRESS_BITS;
  localparam int KW = (ADDRESS_BITS > 32) ? ADDRESS_BITS : 32;

  typedef struct packed {
    logic [7:0]  kind;
    logic [15:0] desc;
    logic [31:0] value;
    logic [31:0] str;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_r;
  logic   [IW-1:0] rd_addr;
  logic   rd_en;

  logic [12:0] entry_count_r;
  logic [31:0] strtab_size_r;
  logic [7:0]  source_type_r, function_type_r, line_type_r, included_type_r;

  logic signed [SW-1:0] left_r, right_r, lo_r, hi_r, mid_r, pick_r, lf_r, rf_r;
  logic [AW-1:0] key_r, addr_r;
  logic [7:0]    want_r;
  logic [31:0]   start_r, noff_r;
  logic          nvalid_r;
  logic [15:0]   line_r;
  out_word_t     result_r;

  logic signed [SW-1:0] count;
  logic signed [SW-1:0] mid_sum;
  logic [KW-1:0]        rd_val, key_ext;
  logic                 fn_found;
  logic [AW-1:0]        addr_off;

  always_comb begin
    if (32'(entry_count_r) > 32'(TABLE_DEPTH)) begin
      count = SW'(TABLE_DEPTH);
    end else begin
      count = SW'(entry_count_r);
    end
    mid_sum  = lo_r + hi_r;
    rd_val   = KW'(rd_r.value);
    key_ext  = KW'(key_r);
    fn_found = (left_r != lf_r);
    addr_off = AW'(KW'(addr_r) - rd_val);
    rd_en    = (cmd == CMD_RD_PICK) || (cmd == CMD_RD_LEFT);
    rd_addr  = (cmd == CMD_RD_LEFT) ? left_r[IW-1:0] : pick_r[IW-1:0];
  end

  assign status.loop_done  = (lo_r > hi_r);
  assign status.pick_below = (pick_r < lo_r);
  assign status.kind_hit   = (rd_r.kind == want_r);
  assign status.left_zero  = (left_r == '0);
  assign status.scan_below = (pick_r < lf_r);
  assign status.scan_stop  = (rd_r.kind == included_type_r) ||
                             ((rd_r.kind == source_type_r) && (rd_r.value != '0));
  assign result = result_r;

  always_ff @(posedge clk) begin
    if ((cmd == CMD_LOAD) && (32'(in_word.entry_index) < 32'(TABLE_DEPTH))) begin
      mem[IW'(in_word.entry_index)] <= '{in_word.entry_kind, in_word.entry_description,
                                          in_word.entry_value, in_word.entry_string};
    end
    if (rd_en) begin
      rd_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      strtab_size_r   <= '0;
      source_type_r   <= 8'd100;
      function_type_r <= 8'd36;
      line_type_r     <= 8'd68;
      included_type_r <= 8'd132;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ENTRY_COUNT:   entry_count_r   <= cfg_data[12:0];
        REG_STRTAB_SIZE:   strtab_size_r   <= cfg_data;
        REG_SOURCE_TYPE:   source_type_r   <= cfg_data[7:0];
        REG_FUNCTION_TYPE: function_type_r <= cfg_data[7:0];
        REG_LINE_TYPE:     line_type_r     <= cfg_data[7:0];
        REG_INCLUDED_TYPE: included_type_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      CMD_INIT_FILE: begin
        addr_r  <= AW'(in_word.query_address);
        key_r   <= AW'(in_word.query_address);
        left_r  <= '0;
        lo_r    <= '0;
        right_r <= count - SW'(1);
        hi_r    <= count - SW'(1);
        want_r  <= source_type_r;
      end
      CMD_MID: begin
        mid_r  <= mid_sum >>> 1;
        pick_r <= mid_sum >>> 1;
      end
      CMD_LO_UP: lo_r <= mid_r + SW'(1);
      CMD_DEC:   pick_r <= pick_r - SW'(1);
      CMD_CMP: begin
        if (rd_val < key_ext) begin
          left_r <= pick_r;
          lo_r   <= pick_r + SW'(1);
        end else if (rd_val > key_ext) begin
          right_r <= pick_r;
          hi_r    <= pick_r - SW'(1);
        end else begin
          left_r <= pick_r;
          lo_r   <= pick_r;
          key_r  <= key_r + AW'(1);
        end
      end
      CMD_INIT_FUNC: begin
        lf_r   <= left_r;
        rf_r   <= right_r;
        lo_r   <= left_r;
        hi_r   <= right_r;
        key_r  <= addr_r;
        want_r <= function_type_r;
      end
      CMD_FUNC_APPLY: begin
        want_r <= line_type_r;
        if (fn_found) begin
          nvalid_r <= (rd_r.str < strtab_size_r);
          noff_r   <= (rd_r.str < strtab_size_r) ? rd_r.str : '0;
          start_r  <= rd_r.value;
          addr_r   <= addr_off;
          key_r    <= addr_off;
          lo_r     <= left_r;
          hi_r     <= right_r;
        end else begin
          nvalid_r <= 1'b0;
          noff_r   <= '0;
          start_r  <= 32'(addr_r);
          key_r    <= addr_r;
          left_r   <= lf_r;
          right_r  <= rf_r;
          lo_r     <= lf_r;
          hi_r     <= rf_r;
        end
      end
      CMD_LINE_APPLY: begin
        line_r <= rd_r.desc;
        pick_r <= left_r;
      end
      CMD_FAIL:
        result_r <= '{1'b1, 1'b0, 32'd0, 1'b0, 32'd0, 32'(addr_r), 16'd0};
      CMD_FILE_NONE:
        result_r <= '{1'b0, 1'b0, 32'd0, nvalid_r, noff_r, start_r, line_r};
      CMD_FILE_APPLY:
        result_r <= '{1'b0, (rd_r.str < strtab_size_r),
                      (rd_r.str < strtab_size_r) ? rd_r.str : 32'd0,
                      nvalid_r, noff_r, start_r, line_r};
      default: ;
    endcase
  end

endmodule

>>> rtl/stal_controller.sv
// Controller: sequences the three typed searches and the file name scan.
module stal_controller (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 action,
  input  stal_pkg::dp_status_t status,
  output stal_pkg::cmd_t       cmd,
  output logic                 busy,
  output logic                 out_valid
);
  import stal_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_LOOP      = 8'b0000_0010,
    ST_PICK      = 8'b0000_0100,
    ST_DATA      = 8'b0000_1000,
    ST_FN_DATA   = 8'b0001_0000,
    ST_LN_DATA   = 8'b0010_0000,
    ST_SCAN      = 8'b0100_0000,
    ST_SCAN_DATA = 8'b1000_0000
  } state_t;

  typedef enum logic [2:0] {
    PH_FILE = 3'b001,
    PH_FUNC = 3'b010,
    PH_LINE = 3'b100
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmd           = CMD_NONE;
    out_valid_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          if (action) begin
            cmd       = CMD_INIT_FILE;
            phase_nxt = PH_FILE;
            state_nxt = ST_LOOP;
          end else begin
            cmd = CMD_LOAD;
          end
        end
      end
      ST_LOOP: begin
        if (!status.loop_done) begin
          cmd       = CMD_MID;
          state_nxt = ST_PICK;
        end else begin
          case (phase_r)
            PH_FILE: begin
              if (status.left_zero) begin
                cmd           = CMD_FAIL;
                out_valid_nxt = 1'b1;
                state_nxt     = ST_IDLE;
              end else begin
                cmd       = CMD_INIT_FUNC;
                phase_nxt = PH_FUNC;
              end
            end
            PH_FUNC: begin
              cmd       = CMD_RD_LEFT;
              state_nxt = ST_FN_DATA;
            end
            default: begin
              cmd       = CMD_RD_LEFT;
              state_nxt = ST_LN_DATA;
            end
          endcase
        end
      end
      ST_PICK: begin
        if (status.pick_below) begin
          cmd       = CMD_LO_UP;
          state_nxt = ST_LOOP;
        end else begin
          cmd       = CMD_RD_PICK;
          state_nxt = ST_DATA;
        end
      end
      ST_DATA: begin
        if (status.kind_hit) begin
          cmd       = CMD_CMP;
          state_nxt = ST_LOOP;
        end else begin
          cmd       = CMD_DEC;
          state_nxt = ST_PICK;
        end
      end
      ST_FN_DATA: begin
        cmd       = CMD_FUNC_APPLY;
        phase_nxt = PH_LINE;
        state_nxt = ST_LOOP;
      end
      ST_LN_DATA: begin
        cmd       = CMD_LINE_APPLY;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (status.scan_below) begin
          cmd           = CMD_FILE_NONE;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd       = CMD_RD_PICK;
          state_nxt = ST_SCAN_DATA;
        end
      end
      ST_SCAN_DATA: begin
        if (status.scan_stop) begin
          cmd           = CMD_FILE_APPLY;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd       = CMD_DEC;
          state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_FILE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state register lost one-hot coding");
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a lookup in progress");
  a_result_ends_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("block still busy as its result is shown");
  a_lookup_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && action) |=> busy)
    else $error("accepted lookup did not start");
  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !action) |=> (!busy && !out_valid))
    else $error("load word caused work or a result");

endmodule
